// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks used by the convolution design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: design/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg
// shared constants and types of the rgba window convolution
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_SIDE_DEF    = 9;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int IN_W       = 16;
  localparam int TAP_IDX_W  = 7;
  localparam int OUT_X_W    = 10;
  localparam int OUT_Y_W    = 12;
  localparam int SUM_W      = 24;
  localparam int FRAC_SHIFT = 14;

  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 120;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int HALF_REG_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd2;

  localparam logic OP_TAP   = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic clr;
    logic prod_en;
    logic tap_ok;
    logic acc_en;
  } rwc_ctl_t;

endpackage

// File: design/rwc_ram.sv
// ----------------------------------------------------------------------------
// rwc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 81
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/rwc_mac.sv
// ----------------------------------------------------------------------------
// rwc_mac
// four channel multiply-accumulate lane with floor shift and saturation
// ----------------------------------------------------------------------------
module rwc_mac import rwc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rwc_ctl_t                 ctl_i,
  input  logic [4*SAMPLE_BITS-1:0] pix_i,
  input  logic [4*SAMPLE_BITS-1:0] coef_i,
  output logic [4*SUM_W-1:0]       sums_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = 2 * SB;
  localparam int ACCW = (2 * SB + 7 > 26) ? 2 * SB + 7 : 26;
  localparam logic signed [ACCW-1:0] SMAX = ACCW'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [ACCW-1:0] SMIN = -ACCW'(1 << (SUM_W - 1));

  logic signed [PW-1:0]   prod_q [4];
  logic signed [ACCW-1:0] acc_q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctl_i.clr) begin
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctl_i.acc_en) begin
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= acc_q[i] + ACCW'(prod_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed(pix_i[i*SB +: SB]) *
                     (ctl_i.tap_ok ? $signed(coef_i[i*SB +: SB]) : $signed(SB'(0)));
      end
    end
  end

  always_comb begin
    logic signed [ACCW-1:0] sh;
    for (int i = 0; i < 4; i++) begin
      sh = acc_q[i] >>> FRAC_SHIFT;
      if (sh > SMAX) begin
        sums_o[i*SUM_W +: SUM_W] = SUM_W'(SMAX);
      end else if (sh < SMIN) begin
        sums_o[i*SUM_W +: SUM_W] = SUM_W'(SMIN);
      end else begin
        sums_o[i*SUM_W +: SUM_W] = SUM_W'(sh);
      end
    end
  end

endmodule

// File: design/rgba_window_convolution.sv
// ----------------------------------------------------------------------------
// rgba_window_convolution
// streaming 2d convolution of rgba pixels with a square per-tap kernel
// ----------------------------------------------------------------------------
// Words are taken in the idle state only. A pixel word passes the divide,
// slot and write states and, with a complete window (side = 2*half+1), the
// run, drain and finish states; the single four-channel multiply-accumulate
// lane walks the line store ram one tap per cycle. A finished result waits
// in the output register while the next word is taken.
module rgba_window_convolution import rwc_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tap_index, value_c0, value_c1, value_c2, value_c3, zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x, out_y, sum_c0, sum_c1, sum_c2, sum_c3, zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // frame_end
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int SB       = SAMPLE_BITS;
  localparam int DW       = 4 * SB;
  localparam int XW       = $clog2(MAX_WIDTH);
  localparam int WCW      = $clog2(MAX_WIDTH + 1);
  localparam int YW       = OUT_Y_W;
  localparam int HALF_MAX = (MAX_SIDE - 1) / 2;
  localparam int HFW      = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
  localparam int SDW      = $clog2(MAX_SIDE + 1);
  localparam int SLW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int NTAP     = MAX_SIDE * MAX_SIDE;
  localparam int TW       = (NTAP > 1) ? $clog2(NTAP) : 1;
  localparam int LD       = MAX_SIDE * MAX_WIDTH;
  localparam int LAW      = $clog2(LD);
  localparam int SH       = YW + 4;
  localparam int RECIP    = (1 << SH) / MAX_SIDE;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SLOT  = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [HALF_REG_W-1:0]   half_q;
  logic [XW-1:0]           col_q, col_d;
  logic [YW-1:0]           row_q, row_d;
  logic [NTAP-1:0]         tap_vld_q;
  logic [DW-1:0]           px_q;
  logic [YW-1:0]           q_q;
  logic [SLW-1:0]          slot_q, slot_d, rowslot_q, rowslot_d;
  logic [SDW-1:0]          r_q, r_d, c_q, c_d;
  logic [TW-1:0]           t_q, t_d;
  logic [XW-1:0]           colbase_q, colbase_d;
  logic [XW-1:0]           ox_q, ox_d;
  logic [YW-1:0]           oy_q, oy_d;
  logic                    last_q, last_d;
  logic                    p1_q, p2_q, tapok_q, p1_d;
  logic                    m_valid_q;
  logic [M_TDATA_W-1:0]    m_data_q;
  logic                    m_last_q;

  logic [WCW-1:0]          wcl;
  logic [XW-1:0]           wm1, x_c;
  logic [HEIGHT_REG_W-1:0] hcl;
  logic [YW-1:0]           hm1, y_c;
  logic [HFW-1:0]          halfc;
  logic [HFW:0]            two_h;
  logic [SDW-1:0]          side;
  logic [YW+SH:0]          div_prod;
  logic [YW:0]             rem;
  logic [SLW:0]            ws;

  logic                    s_acc, tap_we, line_we, load_out;
  logic [DW-1:0]           tap_wdata, line_rdata, tap_rdata;
  logic [LAW-1:0]          line_waddr, line_raddr;
  logic [4*SUM_W-1:0]      sums;
  rwc_ctl_t                ctl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tap_wdata[i*SB +: SB] = s_axis_tdata[TAP_IDX_W + i*IN_W +: SB];
    end
  end

  // effective geometry
  always_comb begin
    if (width_q == '0) begin
      wcl = WCW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wcl = WCW'(MAX_WIDTH);
    end else begin
      wcl = WCW'(width_q);
    end
    wm1 = XW'(wcl - WCW'(1));
    if (height_q == '0) begin
      hcl = HEIGHT_REG_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      hcl = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      hcl = height_q;
    end
    hm1 = YW'(hcl - HEIGHT_REG_W'(1));
    halfc = (32'(half_q) > 32'(HALF_MAX)) ? HFW'(HALF_MAX) : HFW'(half_q);
    two_h = {halfc, 1'b0};
    side  = SDW'(two_h) + SDW'(1);
    x_c   = (col_q > wm1) ? wm1 : col_q;
    y_c   = (row_q > hm1) ? hm1 : row_q;
  end

  assign div_prod = (YW+SH+1)'(y_c) * (YW+SH+1)'(RECIP);

  always_comb begin
    rem = (YW+1)'(y_c) - (YW+1)'(q_q * MAX_SIDE);
    if (32'(rem) >= 32'(MAX_SIDE)) begin
      rem = rem - (YW+1)'(MAX_SIDE);
    end
    slot_d = SLW'(rem);
  end

  always_comb begin
    if (32'(slot_q) < 32'(two_h)) begin
      ws = (SLW+1)'(slot_q) + (SLW+1)'(MAX_SIDE) - (SLW+1)'(two_h);
    end else begin
      ws = (SLW+1)'(slot_q) - (SLW+1)'(two_h);
    end
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    rowslot_d   = rowslot_q;
    r_d         = r_q;
    c_d         = c_q;
    t_d         = t_q;
    colbase_d   = colbase_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    last_d      = last_q;
    p1_d        = 1'b0;
    line_we     = 1'b0;
    load_out    = 1'b0;
    ctl.clr     = 1'b0;
    ctl.prod_en = p1_q;
    ctl.tap_ok  = tapok_q;
    ctl.acc_en  = p2_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc && s_axis_tuser == OP_PIXEL) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_SLOT;
      end
      ST_SLOT: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        line_we   = 1'b1;
        ox_d      = x_c - XW'(halfc);
        oy_d      = y_c - YW'(halfc);
        colbase_d = x_c - XW'(two_h);
        last_d    = (x_c == wm1) && (y_c == hm1);
        rowslot_d = SLW'(ws);
        r_d       = '0;
        c_d       = '0;
        t_d       = '0;
        if (x_c >= wm1) begin
          col_d = '0;
          row_d = (y_c >= hm1) ? '0 : y_c + YW'(1);
        end else begin
          col_d = x_c + XW'(1);
          row_d = y_c;
        end
        if (32'(x_c) >= 32'(two_h) && 32'(y_c) >= 32'(two_h)) begin
          ctl.clr = 1'b1;
          state_d = ST_RUN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        p1_d = 1'b1;
        t_d  = t_q + TW'(1);
        if (c_q == side - SDW'(1)) begin
          c_d = '0;
          r_d = r_q + SDW'(1);
          rowslot_d = (32'(rowslot_q) == MAX_SIDE - 1) ? '0 : rowslot_q + SLW'(1);
          if (r_q == side - SDW'(1)) begin
            state_d = ST_DRAIN;
          end
        end else begin
          c_d = c_q + SDW'(1);
        end
      end
      ST_DRAIN: begin
        if (!p1_q && !p2_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign tap_we     = s_acc && (s_axis_tuser == OP_TAP) &&
                      (32'(s_axis_tdata[TAP_IDX_W-1:0]) < 32'(NTAP));
  assign line_waddr = LAW'(slot_q * MAX_WIDTH) + LAW'(x_c);
  assign line_raddr = LAW'(rowslot_q * MAX_WIDTH) + LAW'(colbase_q) + LAW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= WIDTH_REG_W'(1024);
      height_q  <= HEIGHT_REG_W'(1024);
      half_q    <= HALF_REG_W'(1);
      col_q     <= '0;
      row_q     <= '0;
      tap_vld_q <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      m_valid_q <= 1'b0;
      r_q       <= '0;
      c_q       <= '0;
      t_q       <= '0;
      rowslot_q <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      r_q       <= r_d;
      c_q       <= c_d;
      t_q       <= t_d;
      rowslot_q <= rowslot_d;
      p1_q      <= p1_d;
      p2_q      <= p1_q;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
          REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
          REG_HALF:   half_q   <= cfg_data_i[HALF_REG_W-1:0];
          default: ;
        endcase
      end
      if (tap_we) begin
        tap_vld_q[TW'(s_axis_tdata[TAP_IDX_W-1:0])] <= 1'b1;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      px_q <= tap_wdata;
    end
    q_q       <= YW'(div_prod >> SH);
    slot_q    <= slot_d;
    colbase_q <= colbase_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    last_q    <= last_d;
    tapok_q   <= tap_vld_q[t_q];
    if (load_out) begin
      m_data_q <= {2'b00, sums, oy_q, OUT_X_W'(ox_q)};
      m_last_q <= last_q;
    end
  end

  rwc_ram #(
    .WIDTH (DW),
    .DEPTH (LD)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (px_q),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  rwc_ram #(
    .WIDTH (DW),
    .DEPTH (NTAP)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (TW'(s_axis_tdata[TAP_IDX_W-1:0])),
    .wdata_i (tap_wdata),
    .raddr_i (t_q),
    .rdata_o (tap_rdata)
  );

  rwc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pix_i  (line_rdata),
    .coef_i (tap_rdata),
    .sums_o (sums)
  );

  `ASSERT_CLK(a_tap_keeps_pos, (s_acc && s_axis_tuser == OP_TAP) |=> ($stable(col_q) && $stable(row_q)), "tap word moved the pixel position")
  `ASSERT_CLK(a_out_from_fin, $rose(m_valid_q) |-> $past(state_q == ST_FIN), "result raised outside finish")
  `ASSERT_NEVER(a_tap_range, (state_q == ST_RUN) && (32'(t_q) >= 32'(NTAP)), "tap counter past kernel")
  `ASSERT_CLK(a_pipe_empty, (state_q == ST_FIN) |-> (!p1_q && !p2_q), "finish with lane busy")

endmodule

// File: test/tb_rgba_window_convolution.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgba_window_convolution
// Self-checking stream testbench of the rgba window convolution. Tap and
// pixel words go in at random pacing. A cycle-free predictor of the line
// rows, the tap store and the raster position gives the expected results of the random phases.
// Each result word is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_rgba_window_convolution import rwc_pkg::*; ();

  typedef struct packed {
    logic [OUT_X_W-1:0]         x;
    logic [OUT_Y_W-1:0]         y;
    logic [3:0][SUM_W-1:0]      sum;
    logic                       frame_end;
  } conv_res_t;

  typedef struct packed {
    logic                       op;
    logic [TAP_IDX_W-1:0]       tap;
    logic [3:0][IN_W-1:0]       val;
    logic                       has_res;
    conv_res_t                  res;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tap_index, value_c0, value_c1, value_c2, value_c3, zero pad
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // operation
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_x, out_y, sum_c0, sum_c1, sum_c2, sum_c3, zero pad
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // frame_end
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rgba_window_convolution i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // predictor state
  logic signed [IN_W-1:0] row_buf [MAX_SIDE_DEF][MAX_WIDTH_DEF][4];
  logic signed [IN_W-1:0] coef [MAX_SIDE_DEF*MAX_SIDE_DEF][4];
  int unsigned col_pos, row_pos;
  int unsigned width_reg, height_reg, half_reg;

  conv_res_t   pending_q[$];
  int          errors, words_sent, results_seen, phases_run;
  int          send_idle_pct, recv_stall_pct, hold_cycles;

  function automatic bit conv_step(input logic op, input logic [TAP_IDX_W-1:0] tap,
                                   input logic [3:0][IN_W-1:0] val,
                                   output conv_res_t res);
    int unsigned w, h, hf, x, y, side, rr;
    longint acc, q;
    bit got;
    w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h  = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    hf = (half_reg > (MAX_SIDE_DEF - 1) / 2) ? (MAX_SIDE_DEF - 1) / 2 : half_reg;
    side = 2 * hf + 1;
    res = '0;
    got = 1'b0;
    if (op == OP_TAP) begin
      if (tap < MAX_SIDE_DEF * MAX_SIDE_DEF)
        for (int ch = 0; ch < 4; ch++) coef[tap][ch] = val[ch];
      return 1'b0;
    end
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    for (int ch = 0; ch < 4; ch++) row_buf[y % MAX_SIDE_DEF][x][ch] = val[ch];
    if (x >= 2 * hf && y >= 2 * hf) begin
      for (int ch = 0; ch < 4; ch++) begin
        acc = 0;
        for (int r = 0; r < side; r++) begin
          rr = (y - 2 * hf + r) % MAX_SIDE_DEF;
          for (int c = 0; c < side; c++)
            acc += longint'(row_buf[rr][x - 2 * hf + c][ch]) *
                   longint'(coef[r * side + c][ch]);
        end
        q = acc >>> FRAC_SHIFT;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        res.sum[ch] = q[SUM_W-1:0];
      end
      res.x = OUT_X_W'(x - hf);
      res.y = OUT_Y_W'(y - hf);
      res.frame_end = (x == w - 1) && (y == h - 1);
      got = 1'b1;
    end
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    return got;
  endfunction

  // result side: stall pattern, long hold, checking
  always @(posedge clk_i) begin
    conv_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[9:0];
        got.y = m_axis_tdata[21:10];
        got.sum[0] = m_axis_tdata[45:22];
        got.sum[1] = m_axis_tdata[69:46];
        got.sum[2] = m_axis_tdata[93:70];
        got.sum[3] = m_axis_tdata[117:94];
        got.frame_end = m_axis_tlast;
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("result word with nothing expected: x=%0d y=%0d", got.x, got.y);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %0d got %0d", want.x, got.x); errors++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %0d got %0d", want.y, got.y); errors++;
          end
          for (int ch = 0; ch < 4; ch++)
            if (got.sum[ch] !== want.sum[ch]) begin
              $error("sum_c%0d expected %0d got %0d", ch,
                     $signed(want.sum[ch]), $signed(got.sum[ch]));
              errors++;
            end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end expected %0d got %0d", want.frame_end, got.frame_end);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [TAP_IDX_W-1:0] tap,
                           input logic [3:0][IN_W-1:0] val,
                           input bit typed = 0, input bit typed_has = 0,
                           input conv_res_t typed_res = '0);
    conv_res_t res;
    bit got;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, val[3], val[2], val[1], val[0], tap};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    got = conv_step(op, tap, val, res);
    if (typed) begin
      if (typed_has) pending_q.push_back(typed_res);
    end else if (got) begin
      pending_q.push_back(res);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = data & 32'h7ff;
      REG_HEIGHT: height_reg = data & 32'h1fff;
      REG_HALF:   half_reg   = data & 32'h7;
      default: ;
    endcase
  endtask

  function automatic logic [IN_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return IN_W'($urandom());
    endcase
  endfunction

  function automatic logic [3:0][IN_W-1:0] rand_vals();
    logic [3:0][IN_W-1:0] v;
    for (int ch = 0; ch < 4; ch++) v[ch] = rand_sample();
    return v;
  endfunction

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // whole frames at one setting; starts and ends on a frame boundary
  task automatic run_frames(input int unsigned w_raw, input int unsigned h_raw,
                            input int unsigned half_raw, input int frames,
                            input int mode, input int tap_noise_pct);
    int unsigned w, h, hf, side;
    wait_drained();
    write_reg(REG_WIDTH, w_raw);
    write_reg(REG_HEIGHT, h_raw);
    write_reg(REG_HALF, half_raw);
    set_pacing(mode);
    phases_run++;
    w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h  = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    hf = (half_reg > 4) ? 4 : half_reg;
    side = 2 * hf + 1;
    for (int t = 0; t < side * side; t++) send_word(OP_TAP, TAP_IDX_W'(t), rand_vals());
    for (int f = 0; f < frames; f++)
      for (int p = 0; p < w * h; p++) begin
        if ($urandom_range(99) < tap_noise_pct)
          send_word(OP_TAP, TAP_IDX_W'($urandom_range(127)), rand_vals());
        send_word(OP_PIXEL, TAP_IDX_W'($urandom_range(127)), rand_vals());
      end
  endtask

  stim_row_t dir_tab[$];

  function automatic stim_row_t mk_row(input logic op, input int tap,
                                       input logic [15:0] v0, input logic [15:0] v1,
                                       input logic [15:0] v2, input logic [15:0] v3);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.tap = TAP_IDX_W'(tap);
    r.val = {v3, v2, v1, v0};
    return r;
  endfunction

  initial begin
    stim_row_t row;
    errors = 0; words_sent = 0; results_seen = 0; phases_run = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    for (int r = 0; r < MAX_SIDE_DEF; r++)
      for (int c = 0; c < MAX_WIDTH_DEF; c++)
        for (int ch = 0; ch < 4; ch++) row_buf[r][c][ch] = '0;
    for (int t = 0; t < MAX_SIDE_DEF * MAX_SIDE_DEF; t++)
      for (int ch = 0; ch < 4; ch++) coef[t][ch] = '0;
    col_pos = 0; row_pos = 0;
    width_reg = 1024; height_reg = 1024; half_reg = 1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 image, 3x3 kernel with only the centre tap at 1.0
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_HALF, 1);
    dir_tab.push_back(mk_row(OP_TAP, 4, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
    dir_tab.push_back(mk_row(OP_TAP, 127, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    dir_tab.push_back(mk_row(OP_TAP, 81, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    dir_tab.push_back(mk_row(OP_TAP, 80, 16'h7fff, 16'h8000, 16'hffff, 16'h0001));
    dir_tab.push_back(mk_row(OP_TAP, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    dir_tab.push_back(mk_row(OP_PIXEL, 127, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'hffff, 16'h0000, 16'h1234, 16'h5678));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'h0001, 16'h0002, 16'h0003, 16'h0004));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'h8000, 16'h7fff, 16'h0001, 16'hffff));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    dir_tab.push_back(mk_row(OP_PIXEL, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    row = mk_row(OP_PIXEL, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    row.has_res = 1'b1;
    row.res.x = OUT_X_W'(1);
    row.res.y = OUT_Y_W'(1);
    row.res.sum = {24'hffffff, 24'h000001, 24'h007fff, 24'hff8000};
    row.res.frame_end = 1'b1;
    dir_tab.push_back(row);
    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].tap, dir_tab[i].val, 1,
                dir_tab[i].has_res, dir_tab[i].res);

    // register extremes: zero width and height, out-of-range half codes
    run_frames(0, 0, 0, 1, 0, 0);
    run_frames(12, 10, 7, 1, 3, 5);
    run_frames(9, 9, 4, 1, 0, 0);

    // the receiver holds off while the sender keeps offering words
    wait_drained();
    hold_cycles = 3000;
    run_frames(8, 6, 1, 2, 0, 0);

    while (words_sent < 1000) begin
      int unsigned w, h, hf;
      hf = $urandom_range(7);
      w  = ($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 16);
      h  = $urandom_range(1, 12);
      run_frames(w, h, hf, $urandom_range(1, 2), phases_run % 4, 8);
    end

    wait_drained();
    $display("sent %0d words over %0d register settings, checked %0d results",
             words_sent, phases_run, results_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
